FILE: rtl/mmf_pkg.sv
// ----------------------------------------------------------------------------
// mmf_pkg: shared types and helpers for the 3x3 median/mean filter
// Pixel and column types, register indexes, mean reciprocal and the small
// compare-and-select functions used by the window cells and the stats pipe.
// ----------------------------------------------------------------------------
package mmf_pkg;

  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int MAX_HEIGHT_DEF   = 1024;
  localparam int PIX_W            = 8;
  localparam int CFG_W            = 11;
  localparam int CFG_IDX_W        = 2;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // sum of nine pixels, and 2^16/9 rounded up: exact truncated mean up to 9*255
  localparam int                 SUM_W      = 12;
  localparam int                 RECIP_W    = 13;
  localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;
  localparam int                 MEAN_SHIFT = 16;

  localparam logic MODE_MEDIAN = 1'b0;
  localparam logic MODE_MEAN   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MODE         = 2'd2
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  // one window column, top row first
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } pix3_t;

  typedef struct packed {
    logic interior;
    logic last;
    logic mode;
  } item_ctl_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // ascending: top = smallest, bot = largest
  function automatic pix3_t sort3(pix3_t v);
    pix3_t s;
    s.top = min2(min2(v.top, v.mid), v.bot);
    s.mid = med3(v.top, v.mid, v.bot);
    s.bot = max2(max2(v.top, v.mid), v.bot);
    return s;
  endfunction

endpackage

FILE: rtl/mmf_line_mem.sv
// ----------------------------------------------------------------------------
// mmf_line_mem: one line store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module mmf_line_mem #(
  parameter int DEPTH = mmf_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  mmf_pkg::pix_t            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output mmf_pkg::pix_t            rdata
);

  mmf_pkg::pix_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mmf_wcell.sv
// ----------------------------------------------------------------------------
// mmf_wcell: one column of the 3x3 window
// Loads its input column (the new column or its neighbor's) on every shift and presents the column sorted.
// ----------------------------------------------------------------------------
module mmf_wcell (
  input  logic           clk,
  input  logic           shift,
  input  mmf_pkg::pix3_t col_in,
  output mmf_pkg::pix3_t col,
  output mmf_pkg::pix3_t col_sorted
);

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

  assign col_sorted = mmf_pkg::sort3(col);

endmodule

FILE: rtl/mmf_stats.sv
// ----------------------------------------------------------------------------
// mmf_stats: median / mean pipeline and output register
// Stage A: reduce sorted columns to three candidates, add the nine pixels.
// Stage B: median of the candidates, multiply the sum by the reciprocal of 9.
// Output register: pick median, mean or the border pixel.
// ----------------------------------------------------------------------------
module mmf_stats (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  mmf_pkg::pix3_t [2:0]    win,
  input  mmf_pkg::pix3_t [2:0]    win_sorted,
  input  mmf_pkg::pix_t           border,
  input  mmf_pkg::item_ctl_t      ctl,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mmf_pkg::pix_t           out_pix,
  output logic                    out_last
);

  localparam int PROD_W = mmf_pkg::SUM_W + mmf_pkg::RECIP_W;

  logic                        sa_v;
  mmf_pkg::pix_t               sa_lo_max;
  mmf_pkg::pix_t               sa_med_med;
  mmf_pkg::pix_t               sa_hi_min;
  mmf_pkg::pix_t               sa_border;
  logic [mmf_pkg::SUM_W-1:0]   sa_sum;
  mmf_pkg::item_ctl_t          sa_ctl;

  logic                        sb_v;
  mmf_pkg::pix_t               sb_med;
  mmf_pkg::pix_t               sb_border;
  logic [PROD_W-1:0]           sb_prod;
  mmf_pkg::item_ctl_t          sb_ctl;

  logic                        sa_ready;
  logic                        sb_ready;
  logic                        out_free;

  logic [mmf_pkg::SUM_W-1:0]   win_sum;
  mmf_pkg::pix_t               lo_max;
  mmf_pkg::pix_t               med_med;
  mmf_pkg::pix_t               hi_min;

  always_comb begin
    win_sum = '0;
    for (int i = 0; i < 3; i++) begin
      win_sum = win_sum + mmf_pkg::SUM_W'(win[i].top) + mmf_pkg::SUM_W'(win[i].mid)
                + mmf_pkg::SUM_W'(win[i].bot);
    end
    // median of nine = median of (max of lows, median of mids, min of highs)
    lo_max  = mmf_pkg::max2(mmf_pkg::max2(win_sorted[0].top, win_sorted[1].top),
                            win_sorted[2].top);
    med_med = mmf_pkg::med3(win_sorted[0].mid, win_sorted[1].mid, win_sorted[2].mid);
    hi_min  = mmf_pkg::min2(mmf_pkg::min2(win_sorted[0].bot, win_sorted[1].bot),
                            win_sorted[2].bot);
  end

  assign out_free = !out_valid || out_ready;
  assign sb_ready = !sb_v || out_free;
  assign sa_ready = !sa_v || sb_ready;
  assign in_ready = sa_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_v      <= 1'b0;
      sb_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sa_ready) begin
        sa_v <= in_valid;
      end
      if (sb_ready) begin
        sb_v <= sa_v;
      end
      if (out_free) begin
        out_valid <= sb_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && sa_ready) begin
      sa_lo_max  <= lo_max;
      sa_med_med <= med_med;
      sa_hi_min  <= hi_min;
      sa_sum     <= win_sum;
      sa_border  <= border;
      sa_ctl     <= ctl;
    end
    if (sa_v && sb_ready) begin
      sb_med    <= mmf_pkg::med3(sa_lo_max, sa_med_med, sa_hi_min);
      sb_prod   <= PROD_W'(sa_sum) * PROD_W'(mmf_pkg::MEAN_RECIP);
      sb_border <= sa_border;
      sb_ctl    <= sa_ctl;
    end
    if (sb_v && out_free) begin
      if (!sb_ctl.interior) begin
        out_pix <= sb_border;
      end else if (sb_ctl.mode == mmf_pkg::MODE_MEAN) begin
        out_pix <= sb_prod[mmf_pkg::MEAN_SHIFT +: mmf_pkg::PIX_W];
      end else begin
        out_pix <= sb_med;
      end
      out_last <= sb_ctl.last;
    end
  end

endmodule

FILE: rtl/window_3x3_mean_median_filter.sv
// ----------------------------------------------------------------------------
// window_3x3_mean_median_filter: 3x3 median / truncated mean frame filter
// Smooths an 8-bit grey raster stream; border pixels pass through.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one pixel per beat in raster order; tuser marks a drain
//   beat (pixel taken as zero). After each frame send width+1 drain beats to
//   flush the last results. m_axis carries the filtered frame in the same
//   order, tlast on its final pixel. Result i leaves after input beat
//   i+width+1 is taken: the first width+1 beats of a frame give no result.
//   Path: a result reaches m_axis after the beat that completes its window
//   passes the line store read, window shift, two compute stages and output
//   register. Throughput: one beat per cycle on both sides while m_axis is
//   not stalled, set by the single read and write port of each line store.
//   Config: write frame_width/frame_height/mode only while idle; a size write
//   restarts the frame counters. Sizes clamp to 1..MAX_WIDTH / MAX_HEIGHT.
//   Reset: counters and valids clear, registers return to 640x480 median.
//   The line stores need no clearing: every entry a result depends on is
//   written earlier in the same frame.
//   Stall: a waiting result holds m_axis; s_axis keeps taking beats until
//   every pipeline stage is full, then tready drops.
// ----------------------------------------------------------------------------
module window_3x3_mean_median_filter #(
  parameter int MAX_WIDTH  = mmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mmf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mmf_pkg::PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel_in
  input  logic                          s_axis_tuser,   // [0] drain
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mmf_pkg::PIX_W-1:0]     m_axis_tdata,   // [7:0] pixel_out
  output logic                          m_axis_tlast,
  input  logic                          cfg_wr_en,
  input  logic [mmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmf_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 3);
  localparam int ORW   = $clog2(MAX_HEIGHT);
  localparam int W_RST = (mmf_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                         MAX_WIDTH : mmf_pkg::FRAME_WIDTH_RST;
  localparam int H_RST = (mmf_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                         MAX_HEIGHT : mmf_pkg::FRAME_HEIGHT_RST;

  // configuration
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic           mode;
  logic [WW-1:0]  cfg_w_clamped;
  logic [HW-1:0]  cfg_h_clamped;

  // position counters
  logic [CW-1:0]  in_col;
  logic [RW-1:0]  in_row;
  logic [CW-1:0]  out_col;
  logic [ORW-1:0] out_row;
  logic [CW-1:0]  in_col_next;
  logic [RW-1:0]  in_row_next;
  logic [CW-1:0]  out_col_next;
  logic [ORW-1:0] out_row_next;

  logic [CW-1:0]  ic;
  logic [WW-1:0]  ic_ext;
  logic [WW-1:0]  oc_ext;
  logic [HW-1:0]  or_ext;
  logic           col_end;
  logic           emit;
  logic           interior;
  logic           last;
  logic           in_accept;

  // stage 1: line store read in flight
  logic           s1_v;
  logic [CW-1:0]  s1_addr;
  mmf_pkg::pix_t  s1_x;
  logic           s1_emit;
  logic           s1_interior;
  logic           s1_last;
  logic           s1_fwd;
  mmf_pkg::pix_t  s1_fwd_top;
  mmf_pkg::pix_t  s1_fwd_mid;
  mmf_pkg::pix_t  s1_top;
  mmf_pkg::pix_t  s1_mid;
  mmf_pkg::pix_t  upper_rdata;
  mmf_pkg::pix_t  lower_rdata;
  logic           s1_move;

  // stage 2: window holds the item
  logic               s2_v;
  logic               s2_emit;
  mmf_pkg::item_ctl_t s2_ctl;
  logic               s2_ready;
  logic               s2_leave;
  logic               st_in_ready;

  mmf_pkg::pix3_t [2:0] win;
  mmf_pkg::pix3_t [2:0] win_sorted;
  mmf_pkg::pix3_t [2:0] cell_in;

  // ---------------------------------------------------------------- config
  always_comb begin
    cfg_w_clamped = WW'(MAX_WIDTH);
    if (cfg_data == '0) begin
      cfg_w_clamped = WW'(1);
    end else if (int'(cfg_data) <= MAX_WIDTH) begin
      cfg_w_clamped = WW'(cfg_data);
    end
    cfg_h_clamped = HW'(MAX_HEIGHT);
    if (cfg_data == '0) begin
      cfg_h_clamped = HW'(1);
    end else if (int'(cfg_data) <= MAX_HEIGHT) begin
      cfg_h_clamped = HW'(cfg_data);
    end
  end

  // ---------------------------------------------------------------- counters
  always_comb begin
    ic      = (WW'(in_col) >= w_eff) ? '0 : in_col;
    ic_ext  = WW'(ic);
    col_end = (ic_ext + WW'(1)) >= w_eff;
    emit    = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (ic != '0));
    oc_ext  = WW'(out_col);
    or_ext  = HW'(out_row);
    interior = (out_row != '0) && ((or_ext + HW'(1)) < h_eff) &&
               (out_col != '0) && ((oc_ext + WW'(1)) < w_eff);
    last     = ((or_ext + HW'(1)) >= h_eff) && ((oc_ext + WW'(1)) >= w_eff);

    in_col_next  = col_end ? '0 : CW'(ic_ext + WW'(1));
    in_row_next  = col_end ? (in_row + RW'(1)) : in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (emit) begin
      if (last) begin
        // frame done: restart everything
        in_col_next  = '0;
        in_row_next  = '0;
        out_col_next = '0;
        out_row_next = '0;
      end else if ((oc_ext + WW'(1)) >= w_eff) begin
        out_col_next = '0;
        out_row_next = out_row + ORW'(1);
      end else begin
        out_col_next = out_col + CW'(1);
      end
    end
  end

  assign s_axis_tready = !s1_v || s2_ready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff   <= WW'(W_RST);
      h_eff   <= HW'(H_RST);
      mode    <= mmf_pkg::MODE_MEDIAN;
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cfg_wr_en) begin
      unique case (mmf_pkg::cfg_reg_t'(cfg_index))
        mmf_pkg::REG_FRAME_WIDTH: begin
          w_eff   <= cfg_w_clamped;
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end
        mmf_pkg::REG_FRAME_HEIGHT: begin
          h_eff   <= cfg_h_clamped;
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end
        mmf_pkg::REG_MODE: begin
          mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // ---------------------------------------------------------------- stage 1
  assign s1_top  = s1_fwd ? s1_fwd_top : upper_rdata;
  assign s1_mid  = s1_fwd ? s1_fwd_mid : lower_rdata;
  assign s1_move = s1_v && s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_accept) begin
      s1_v <= 1'b1;
    end else if (s1_move) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr     <= ic;
      s1_x        <= s_axis_tuser ? '0 : s_axis_tdata;
      s1_emit     <= emit;
      s1_interior <= interior;
      s1_last     <= last;
      // same column written this cycle (one-pixel rows): bypass the store
      s1_fwd      <= s1_move && (s1_addr == ic);
      s1_fwd_top  <= s1_mid;
      s1_fwd_mid  <= s1_x;
    end
  end

  mmf_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_addr),
    .wdata (s1_mid),
    .re    (in_accept),
    .raddr (ic),
    .rdata (upper_rdata)
  );

  mmf_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_lower (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_addr),
    .wdata (s1_x),
    .re    (in_accept),
    .raddr (ic),
    .rdata (lower_rdata)
  );

  // ---------------------------------------------------------------- window
  assign cell_in[2] = '{top: s1_top, mid: s1_mid, bot: s1_x};
  assign cell_in[1] = win[2];
  assign cell_in[0] = win[1];

  for (genvar g = 0; g < 3; g++) begin : g_cell
    mmf_wcell u_cell (
      .clk        (clk),
      .shift      (s1_move),
      .col_in     (cell_in[g]),
      .col        (win[g]),
      .col_sorted (win_sorted[g])
    );
  end

  // ---------------------------------------------------------------- stage 2
  assign s2_ready = !s2_v || !s2_emit || st_in_ready;
  assign s2_leave = s2_v && (!s2_emit || st_in_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s1_move) begin
      s2_v <= 1'b1;
    end else if (s2_leave) begin
      s2_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_emit <= s1_emit;
      s2_ctl  <= '{interior: s1_interior, last: s1_last, mode: mode};
    end
  end

  mmf_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s2_v && s2_emit),
    .in_ready   (st_in_ready),
    .win        (win),
    .win_sorted (win_sorted),
    .border     (win[1].mid),
    .ctl        (s2_ctl),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_pix    (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

FILE: rtl/mmf_checker.sv
// ----------------------------------------------------------------------------
// mmf_checker: port-level checks for the 3x3 filter
// Reset behavior, output hold under stall, no result without prior input.
// ----------------------------------------------------------------------------
module mmf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [mmf_pkg::PIX_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);

  // beats taken minus results delivered
  logic [47:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 48'(s_axis_tvalid && s_axis_tready)
                 - 48'(m_axis_tvalid && m_axis_tready);
    end
  end

  a_reset_clean : assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("pipeline not empty after reset");

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output beat changed while stalled");

  a_no_invented : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pending != '0))
    else $error("result offered without a pending input beat");

endmodule

bind window_3x3_mean_median_filter mmf_checker u_mmf_checker (.*);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for window_3x3_mean_median_filter
// Streams frames of many sizes and both modes through the filter, predicts
// every output pixel with an independent line-store and window model, and
// compares each m_axis beat against the oldest prediction. Covers size
// clamping, size writes mid-frame, drain beats mid-frame, pixel beats used as
// flush, unknown register writes, random stalls on both sides and a long
// output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W        = mmf_pkg::MAX_WIDTH_DEF;
  localparam int unsigned MAX_H        = mmf_pkg::MAX_HEIGHT_DEF;
  localparam int unsigned SETTLE_CYC   = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam logic [mmf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // pixel content styles
  localparam int unsigned PIX_RANDOM   = 0;
  localparam int unsigned PIX_EXTREME  = 1;
  localparam int unsigned PIX_NARROW   = 2;

  typedef struct packed {
    mmf_pkg::pix_t value;
    logic          last;
  } smoothed_t;

  logic                          clk;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [mmf_pkg::PIX_W-1:0]     s_axis_tdata;   // [7:0] pixel_in
  logic                          s_axis_tuser;   // [0] drain
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [mmf_pkg::PIX_W-1:0]     m_axis_tdata;   // [7:0] pixel_out
  logic                          m_axis_tlast;
  logic                          cfg_wr_en;
  logic [mmf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mmf_pkg::CFG_W-1:0]     cfg_data;

  window_3x3_mean_median_filter i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // predictor state
  mmf_pkg::pix_t  upper_row [MAX_W];
  mmf_pkg::pix_t  lower_row [MAX_W];
  mmf_pkg::pix_t  nbhd [9];
  int unsigned    in_col, in_row, out_col, out_row;
  logic [mmf_pkg::CFG_W-1:0] width_reg, height_reg;
  logic           mode_reg;
  smoothed_t      smoothed_q [$];

  int unsigned    items_sent;
  int unsigned    errors;
  int unsigned    idle_cycles;
  int unsigned    hold_left;
  bit             hold_req;
  bit             src_idle_en;
  bit             sink_idle_en;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic mmf_pkg::pix_t nbhd_median();
    mmf_pkg::pix_t s [9];
    mmf_pkg::pix_t t;
    s = nbhd;
    for (int i = 1; i < 9; i++) begin
      for (int j = i; j > 0 && s[j-1] > s[j]; j--) begin
        t      = s[j];
        s[j]   = s[j-1];
        s[j-1] = t;
      end
    end
    return s[4];
  endfunction

  function automatic mmf_pkg::pix_t nbhd_mean();
    int unsigned sum;
    sum = 0;
    for (int i = 0; i < 9; i++) sum += nbhd[i];
    return mmf_pkg::pix_t'(sum / 9);
  endfunction

  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // advance the filter model by one input beat, queue the pixel it releases
  function automatic void smooth_pixel(input mmf_pkg::pix_t pix, input logic drain);
    int unsigned   w, h, ic, r, c;
    mmf_pkg::pix_t x, top, mid, wrapped;
    logic          emit, interior;
    smoothed_t     res;
    w       = clamp_dim(width_reg, MAX_W);
    h       = clamp_dim(height_reg, MAX_H);
    x       = drain ? '0 : pix;
    ic      = (in_col >= w) ? 0 : in_col;
    top     = upper_row[ic];
    mid     = lower_row[ic];
    wrapped = upper_row[w-1];
    nbhd[0] = nbhd[1]; nbhd[1] = nbhd[2]; nbhd[2] = top;
    nbhd[3] = nbhd[4]; nbhd[4] = nbhd[5]; nbhd[5] = mid;
    nbhd[6] = nbhd[7]; nbhd[7] = nbhd[8]; nbhd[8] = x;
    upper_row[ic] = mid;
    lower_row[ic] = x;
    emit = (in_row >= 2) || (in_row == 1 && ic >= 1);
    if (ic + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col = ic + 1;
    end
    if (!emit) return;
    r        = out_row;
    c        = out_col;
    interior = r >= 1 && r + 1 < h && c >= 1 && c + 1 < w;
    if (interior) begin
      res.value = (mode_reg == mmf_pkg::MODE_MEAN) ? nbhd_mean() : nbhd_median();
    end else begin
      res.value = (ic >= 1) ? nbhd[4] : wrapped;
    end
    res.last = (r + 1 >= h) && (c + 1 >= w);
    if (res.last) begin
      restart_frame();
    end else if (c + 1 >= w) begin
      out_col = 0;
      out_row = r + 1;
    end else begin
      out_col = c + 1;
    end
    smoothed_q.push_back(res);
  endfunction

  function automatic mmf_pkg::pix_t gen_pixel(input int unsigned style);
    case (style)
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_NARROW:  return mmf_pkg::pix_t'($urandom_range(120, 123));
      default:     return mmf_pkg::pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // offer one beat, with an occasional gap before it, and wait until taken
  task automatic send_beat(input mmf_pkg::pix_t pix, input logic drain);
    int unsigned gap;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= drain;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    smooth_pixel(pix, drain);
    items_sent++;
  endtask

  // drop valid, let every predicted pixel come out, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mmf_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[mmf_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      mmf_pkg::REG_FRAME_WIDTH: begin
        width_reg = value[mmf_pkg::CFG_W-1:0];
        restart_frame();
      end
      mmf_pkg::REG_FRAME_HEIGHT: begin
        height_reg = value[mmf_pkg::CFG_W-1:0];
        restart_frame();
      end
      mmf_pkg::REG_MODE: mode_reg = value[0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input logic mode);
    wait_idle();
    write_reg(mmf_pkg::REG_FRAME_WIDTH, w);
    write_reg(mmf_pkg::REG_FRAME_HEIGHT, h);
    write_reg(mmf_pkg::REG_MODE, mode);
  endtask

  task automatic send_pixels(input int unsigned n, input int unsigned drain_pct,
                             input int unsigned style);
    for (int unsigned i = 0; i < n; i++)
      send_beat(gen_pixel(style), $urandom_range(0, 99) < drain_pct);
  endtask

  // one whole frame followed by width+1 flush beats
  task automatic send_frame(input int unsigned drain_pct, input int unsigned flush_pix_pct,
                            input int unsigned style);
    int unsigned w, h;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    send_pixels(w * h, drain_pct, style);
    for (int unsigned i = 0; i <= w; i++)
      send_beat(gen_pixel(style), !($urandom_range(0, 99) < flush_pix_pct));
  endtask

  task automatic test_directed();
    mmf_pkg::pix_t board [9] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                                 8'hFF};
    set_frame(3, 3, mmf_pkg::MODE_MEDIAN);
    foreach (board[i]) send_beat(board[i], 1'b0);
    repeat (4) send_beat(gen_pixel(PIX_RANDOM), 1'b1);
    set_frame(3, 3, mmf_pkg::MODE_MEAN);
    repeat (9) send_beat(8'hFF, 1'b0);
    repeat (4) send_beat(8'hFF, 1'b1);
  endtask

  // zero and oversized dimensions, and frames too thin to have an interior
  task automatic test_size_clamp();
    set_frame(0, 0, mmf_pkg::MODE_MEDIAN);
    send_frame(0, 0, PIX_RANDOM);
    set_frame(2, 5, mmf_pkg::MODE_MEAN);
    send_frame(0, 0, PIX_RANDOM);
    set_frame(5, 2, mmf_pkg::MODE_MEDIAN);
    send_frame(0, 0, PIX_RANDOM);
    // oversized frames: the start of each, cut short by the next size write
    set_frame(1, 2047, mmf_pkg::MODE_MEDIAN);
    send_pixels(30, 0, PIX_RANDOM);
    set_frame(2047, 3, mmf_pkg::MODE_MEAN);
    send_pixels(30, 0, PIX_RANDOM);
  endtask

  task automatic test_mid_frame_restart();
    set_frame(6, 5, mmf_pkg::MODE_MEDIAN);
    send_pixels(17, 0, PIX_RANDOM);
    wait_idle();
    write_reg(mmf_pkg::REG_FRAME_HEIGHT, 5);
    send_frame(0, 0, PIX_RANDOM);
    send_pixels(9, 0, PIX_RANDOM);
    wait_idle();
    write_reg(mmf_pkg::REG_FRAME_WIDTH, 6);
    send_frame(0, 0, PIX_NARROW);
    wait_idle();
    write_reg(mmf_pkg::REG_MODE, mmf_pkg::MODE_MEAN);
    send_frame(0, 0, PIX_RANDOM);
  endtask

  task automatic test_unknown_index();
    set_frame(4, 4, mmf_pkg::MODE_MEAN);
    write_reg(REG_UNUSED, 2047);
    send_frame(0, 0, PIX_RANDOM);
    wait_idle();
    write_reg(REG_UNUSED, 0);
    send_frame(0, 0, PIX_EXTREME);
  endtask

  task automatic test_drain_and_flush_pixels();
    set_frame(5, 4, mmf_pkg::MODE_MEDIAN);
    send_frame(20, 100, PIX_RANDOM);
    send_frame(0, 50, PIX_RANDOM);
    set_frame(5, 4, mmf_pkg::MODE_MEAN);
    send_frame(20, 100, PIX_RANDOM);
  endtask

  // hold m_axis long enough that the pipe fills and s_axis_tready drops
  task automatic test_output_hold();
    set_frame(10, 8, mmf_pkg::MODE_MEDIAN);
    src_idle_en = 1'b0;
    hold_req    = 1'b1;
    send_frame(0, 0, PIX_RANDOM);
    src_idle_en = 1'b1;
  endtask

  task automatic test_random_frames(input int unsigned target);
    int unsigned first, w, h, drain_pct, flush_pct, style;
    first = items_sent;
    while (items_sent - first < target) begin
      case ($urandom_range(0, 19))
        0:       w = 0;
        1:       w = $urandom_range(16, 40);
        default: w = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 19))
        0:       h = 0;
        1:       h = $urandom_range(11, 16);
        default: h = $urandom_range(1, 10);
      endcase
      wait_idle();
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom_range(0, 2047));
      write_reg(mmf_pkg::REG_FRAME_WIDTH, w);
      write_reg(mmf_pkg::REG_FRAME_HEIGHT, h);
      write_reg(mmf_pkg::REG_MODE, $urandom_range(0, 1));
      repeat ($urandom_range(1, 3)) begin
        style     = $urandom_range(0, 2);
        drain_pct = ($urandom_range(0, 7) == 0) ? 10 : 0;
        flush_pct = ($urandom_range(0, 4) == 0) ? 50 : 0;
        send_frame(drain_pct, flush_pct, style);
      end
      // leave a frame unfinished; the next size write restarts it
      if ($urandom_range(0, 7) == 0)
        send_pixels($urandom_range(1, clamp_dim(w, MAX_W) * clamp_dim(h, MAX_H)), 0,
                    PIX_RANDOM);
    end
  endtask

  task automatic test_back_to_back();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_frame(9, 7, mmf_pkg::MODE_MEAN);
    send_frame(0, 0, PIX_RANDOM);
    set_frame(8, 5, mmf_pkg::MODE_MEDIAN);
    send_frame(0, 0, PIX_RANDOM);
  endtask

  // output side: random stall bursts and the requested long hold
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end else if (hold_left == 0 && sink_idle_en && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(1, 11);
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    smoothed_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (smoothed_q.size() == 0) begin
        $error("unexpected beat: pixel_out %0d last_of_frame %0b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = smoothed_q.pop_front();
        if (m_axis_tdata !== want.value) begin
          $error("pixel_out: expected %0d, got %0d", want.value, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_frame: expected %0b, got %0b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    items_sent    = 0;
    errors        = 0;
    idle_cycles   = 0;
    hold_left     = 0;
    hold_req      = 1'b0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    foreach (upper_row[i]) upper_row[i] = '0;
    foreach (lower_row[i]) lower_row[i] = '0;
    foreach (nbhd[i]) nbhd[i] = '0;
    width_reg  = mmf_pkg::CFG_W'(mmf_pkg::FRAME_WIDTH_RST);
    height_reg = mmf_pkg::CFG_W'(mmf_pkg::FRAME_HEIGHT_RST);
    mode_reg   = mmf_pkg::MODE_MEDIAN;
    restart_frame();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_size_clamp();
    test_mid_frame_restart();
    test_unknown_index();
    test_drain_and_flush_pixels();
    test_output_hold();
    test_random_frames(200);
    test_back_to_back();
    wait_idle();

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mmf_pkg.sv
rtl/mmf_line_mem.sv
rtl/mmf_wcell.sv
rtl/mmf_stats.sv
rtl/window_3x3_mean_median_filter.sv
rtl/mmf_checker.sv
tb/sv/testbench.sv
